// ----- rtl/harf_pkg.sv -----
// Shared constants, types and the CRC byte function of the haptic report framer.
`default_nettype none
package harf_pkg;

    localparam int FRAME_BYTES_DEF  = 64;
    localparam int REPORT_BYTES_DEF = 142;
    localparam int OUTPUT_RATE      = 3000;

    localparam int RATE_W   = 18;
    localparam int GAIN_W   = 16;
    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 18;
    localparam int WORD_W   = 64;

    localparam int PH_W    = $clog2(OUTPUT_RATE);
    localparam int PHASE_W = RATE_W + 1;
    localparam int SUM_W   = SAMPLE_W + PH_W + 1;
    localparam int NUM_W   = SUM_W + GAIN_W + 1;
    localparam int Q_W     = 8;

    localparam longint DEN          = longint'(OUTPUT_RATE) * 256;
    localparam longint D2           = DEN * 256;
    localparam longint CLAMP_HI     = 32767 * DEN;
    localparam longint CLAMP_LO_MAG = 32768 * DEN;
    localparam int     X_W          = $clog2(CLAMP_LO_MAG + D2) + 1;

    // D2 = 375 * 2^19: shift out the power of two, then multiply by the
    // reciprocal of the odd part, exact for every dividend below 2^17
    localparam int     DIV_PRE  = 19;
    localparam int     DIV_ODD  = int'(D2 >> DIV_PRE);
    localparam int     RECIP_SH = 25;
    localparam int     RECIP_W  = 17;
    localparam logic [RECIP_W-1:0] RECIP_M =
        RECIP_W'(((longint'(1) << RECIP_SH) + DIV_ODD - 1) / DIV_ODD);

    localparam logic CFG_IDX_RATE = 1'b0;
    localparam logic CFG_IDX_GAIN = 1'b1;

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);

    localparam logic [7:0]  REPORT_ID  = 8'h32;
    localparam logic [7:0]  SUB_HEADER = 8'h12 | 8'h80;
    localparam logic [7:0]  CRC_PREFIX = 8'hA2;
    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [31:0] CRC_ONES   = 32'hFFFFFFFF;
    localparam logic [3:0]  SEQ_MASK   = 4'hF;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'h0, b};
        for (int k = 0; k < 8; k++)
        begin
            r = r[0] ? (CRC_POLY ^ (r >> 1)) : (r >> 1);
        end
        return r;
    endfunction

    localparam logic [31:0] CRC_SEED = crc_byte(CRC_ONES, CRC_PREFIX);

    typedef struct packed {
        logic accept;
        logic start_b;
        logic phase_sub;
        logic phase_add;
        logic chan;
        logic mul1;
        logic mul2;
        logic absq;
        logic div_step;
        logic push;
        logic rpt_start;
        logic rpt_rd;
        logic rpt_byte;
        logic load_out;
        logic rpt_finish;
    } harf_cmd_t;

    typedef struct packed {
        logic in_action;
        logic in_chunk_end;
        logic have_prev;
        logic count_zero;
        logic phase_lt;
        logic frame_full_next;
        logic chunk_end;
        logic word_done;
        logic word_end;
        logic out_free;
    } harf_sts_t;

endpackage
`default_nettype wire

// ----- rtl/harf_dp.sv -----
// Datapath: resampler state, quantizer, frame memory, CRC and output word register.
`default_nettype none
module harf_dp #(
    parameter int FRAME_BYTES  = harf_pkg::FRAME_BYTES_DEF,
    parameter int REPORT_BYTES = harf_pkg::REPORT_BYTES_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic                                 cfg_index,
    input  wire logic [harf_pkg::CFG_W-1:0]           cfg_data,
    input  wire logic                                 action,
    input  wire logic signed [harf_pkg::SAMPLE_W-1:0] left_sample,
    input  wire logic signed [harf_pkg::SAMPLE_W-1:0] right_sample,
    input  wire logic                                 chunk_end,
    input  wire logic                                 out_stall,
    input  wire harf_pkg::harf_cmd_t                  cmd,
    output harf_pkg::harf_sts_t                       sts,
    output logic                                      out_valid,
    output logic [harf_pkg::WORD_W-1:0]               report_word,
    output logic [3:0]                                bytes_valid,
    output logic                                      report_end
);

    localparam int AW    = $clog2(FRAME_BYTES);
    localparam int CNT_W = $clog2(FRAME_BYTES + 1);
    localparam int IDX_W = $clog2(REPORT_BYTES);
    localparam int CMP_W = (IDX_W > CNT_W) ? IDX_W : CNT_W;
    localparam int Y_W   = harf_pkg::X_W - harf_pkg::DIV_PRE;
    localparam int P_W   = Y_W + harf_pkg::RECIP_W;
    localparam logic [IDX_W-1:0] CRC_START = IDX_W'(REPORT_BYTES - 4);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(REPORT_BYTES - 1);
    localparam logic [IDX_W-1:0] HDR_LEN   = IDX_W'(4);
    localparam logic [CNT_W-1:0] FULL_M1   = CNT_W'(FRAME_BYTES - 1);
    localparam logic [harf_pkg::X_W-1:0] HALF_X = harf_pkg::X_W'(harf_pkg::D2 / 2);
    localparam logic [harf_pkg::X_W-1:0] HI_X   = harf_pkg::X_W'(harf_pkg::CLAMP_HI);
    localparam logic [harf_pkg::X_W-1:0] LO_X   = harf_pkg::X_W'(harf_pkg::CLAMP_LO_MAG);
    localparam logic signed [harf_pkg::NUM_W-1:0] HI_N =
        harf_pkg::NUM_W'(harf_pkg::CLAMP_HI);
    localparam logic signed [harf_pkg::NUM_W-1:0] LO_N =
        harf_pkg::NUM_W'(-harf_pkg::CLAMP_LO_MAG);

    logic [harf_pkg::RATE_W-1:0] rate_reg;
    logic [harf_pkg::GAIN_W-1:0] gain_reg;
    logic [harf_pkg::PHASE_W-1:0] phase_reg;
    logic signed [harf_pkg::SAMPLE_W-1:0] prev_l_reg, prev_r_reg;
    logic signed [harf_pkg::SAMPLE_W-1:0] a_l_reg, a_r_reg, b_l_reg, b_r_reg;
    logic have_prev_reg, ce_reg;
    logic signed [harf_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic signed [harf_pkg::NUM_W-1:0] num_reg, num_next;
    logic [harf_pkg::X_W-1:0] x_reg, x_next;
    logic [Y_W-1:0] y_div;
    logic [P_W-1:0] recip_prod;
    logic neg_reg, neg_next;
    logic [harf_pkg::Q_W-1:0] q_reg, qbyte;
    logic [7:0] mem [FRAME_BYTES];
    logic [7:0] mem_rd_reg;
    logic [CNT_W-1:0] count_reg;
    logic [3:0] seq_reg;
    logic [31:0] crc_reg, crc_out;
    logic [IDX_W-1:0] idx_reg, pidx, cidx;
    logic [harf_pkg::WORD_W-1:0] wbuf_reg;
    logic [3:0] wlen_reg;
    logic wend_reg;
    logic out_valid_reg;
    logic [harf_pkg::WORD_W-1:0] out_word_reg;
    logic [3:0] out_len_reg;
    logic out_end_reg;
    logic [harf_pkg::RATE_W-1:0] step;
    logic [harf_pkg::PH_W-1:0] ph;
    logic signed [harf_pkg::SAMPLE_W-1:0] sa, sb;
    logic signed [harf_pkg::PH_W:0] w_a, w_b;
    logic [7:0] rbyte;
    logic out_free;

    assign step = (rate_reg < harf_pkg::RATE_W'(harf_pkg::OUTPUT_RATE)) ?
                  harf_pkg::RATE_W'(harf_pkg::OUTPUT_RATE) : rate_reg;
    assign ph   = phase_reg[harf_pkg::PH_W-1:0];
    assign sa   = cmd.chan ? a_r_reg : a_l_reg;
    assign sb   = cmd.chan ? b_r_reg : b_l_reg;
    assign w_a  = $signed((harf_pkg::PH_W+1)'(harf_pkg::OUTPUT_RATE) - {1'b0, ph});
    assign w_b  = $signed({1'b0, ph});

    always_comb
    begin
        sum_next = harf_pkg::SUM_W'(sa) * harf_pkg::SUM_W'(w_a)
                 + harf_pkg::SUM_W'(sb) * harf_pkg::SUM_W'(w_b);
        num_next = sum_reg * $signed({1'b0, gain_reg});
        if (num_reg > HI_N)
        begin
            x_next   = HI_X + HALF_X;
            neg_next = 1'b0;
        end
        else if (num_reg < LO_N)
        begin
            x_next   = LO_X + HALF_X;
            neg_next = 1'b1;
        end
        else if (num_reg < 0)
        begin
            x_next   = harf_pkg::X_W'(-num_reg) + HALF_X;
            neg_next = 1'b1;
        end
        else
        begin
            x_next   = harf_pkg::X_W'(num_reg) + HALF_X;
            neg_next = 1'b0;
        end
    end

    // divide the rounded magnitude by the fixed scale: shift, then reciprocal multiply
    assign y_div      = x_reg[harf_pkg::X_W-1:harf_pkg::DIV_PRE];
    assign recip_prod = P_W'(y_div) * P_W'(harf_pkg::RECIP_M);
    assign qbyte      = neg_reg ? (~q_reg + 8'd1) : (q_reg[7] ? 8'd127 : q_reg);

    // report byte for the current index
    assign pidx    = idx_reg - HDR_LEN;
    assign cidx    = idx_reg - CRC_START;
    assign crc_out = ~crc_reg;

    always_comb
    begin
        if (idx_reg >= CRC_START)
            rbyte = crc_out[8*cidx[1:0] +: 8];
        else if (idx_reg == IDX_W'(0))
            rbyte = harf_pkg::REPORT_ID;
        else if (idx_reg == IDX_W'(1))
            rbyte = {seq_reg, 4'h0};
        else if (idx_reg == IDX_W'(2))
            rbyte = harf_pkg::SUB_HEADER;
        else if (idx_reg == IDX_W'(3))
            rbyte = 8'(FRAME_BYTES);
        else if (CMP_W'(pidx) < CMP_W'(count_reg))
            rbyte = mem_rd_reg;
        else
            rbyte = 8'h00;
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.push)
            mem[count_reg[AW-1:0]] <= qbyte;
        if (cmd.rpt_rd)
            mem_rd_reg <= mem[pidx[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg      <= harf_pkg::RATE_RESET;
            gain_reg      <= harf_pkg::GAIN_RESET;
            phase_reg     <= '0;
            prev_l_reg    <= '0;
            prev_r_reg    <= '0;
            have_prev_reg <= 1'b0;
            count_reg     <= '0;
            seq_reg       <= '0;
            crc_reg       <= harf_pkg::CRC_ONES;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    harf_pkg::CFG_IDX_RATE: rate_reg <= cfg_data[harf_pkg::RATE_W-1:0];
                    harf_pkg::CFG_IDX_GAIN: gain_reg <= cfg_data[harf_pkg::GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.accept && !action)
            begin
                prev_l_reg    <= left_sample;
                prev_r_reg    <= right_sample;
                have_prev_reg <= !chunk_end;
            end
            if (cmd.phase_sub)
                phase_reg <= phase_reg - harf_pkg::PHASE_W'(harf_pkg::OUTPUT_RATE);
            else if (cmd.phase_add)
                phase_reg <= phase_reg + harf_pkg::PHASE_W'(step);
            if (cmd.push)
                count_reg <= count_reg + CNT_W'(1);
            if (cmd.rpt_start)
            begin
                idx_reg <= '0;
                crc_reg <= harf_pkg::CRC_SEED;
            end
            else if (cmd.rpt_byte)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
                if (idx_reg < CRC_START)
                    crc_reg <= harf_pkg::crc_byte(crc_reg, rbyte);
            end
            if (cmd.rpt_finish)
            begin
                count_reg <= '0;
                seq_reg   <= (seq_reg + 4'd1) & harf_pkg::SEQ_MASK;
                crc_reg   <= harf_pkg::CRC_ONES;
            end
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            ce_reg  <= chunk_end;
            b_l_reg <= left_sample;
            b_r_reg <= right_sample;
            a_l_reg <= have_prev_reg ? prev_l_reg : left_sample;
            a_r_reg <= have_prev_reg ? prev_r_reg : right_sample;
        end
        if (cmd.start_b)
        begin
            a_l_reg <= b_l_reg;
            a_r_reg <= b_r_reg;
        end
        if (cmd.mul1)
            sum_reg <= sum_next;
        if (cmd.mul2)
            num_reg <= num_next;
        if (cmd.absq)
        begin
            x_reg   <= x_next;
            neg_reg <= neg_next;
        end
        if (cmd.div_step)
            q_reg <= recip_prod[harf_pkg::RECIP_SH +: harf_pkg::Q_W];
        if (cmd.rpt_start)
            wbuf_reg <= '0;
        else if (cmd.rpt_byte)
        begin
            wbuf_reg[8*idx_reg[2:0] +: 8] <= rbyte;
            wlen_reg <= {1'b0, idx_reg[2:0]} + 4'd1;
            wend_reg <= (idx_reg == LAST_IDX);
        end
        else if (cmd.load_out)
            wbuf_reg <= '0;
        if (cmd.load_out)
        begin
            out_word_reg <= wbuf_reg;
            out_len_reg  <= wlen_reg;
            out_end_reg  <= wend_reg;
        end
    end

    always_comb
    begin
        sts.in_action       = action;
        sts.in_chunk_end    = chunk_end;
        sts.have_prev       = have_prev_reg;
        sts.count_zero      = (count_reg == '0);
        sts.phase_lt        = phase_reg < harf_pkg::PHASE_W'(harf_pkg::OUTPUT_RATE);
        sts.frame_full_next = (count_reg == FULL_M1);
        sts.chunk_end       = ce_reg;
        sts.word_done       = (idx_reg[2:0] == 3'd7) || (idx_reg == LAST_IDX);
        sts.word_end        = wend_reg;
        sts.out_free        = out_free;
    end

    assign out_valid   = out_valid_reg;
    assign report_word = out_word_reg;
    assign bytes_valid = out_len_reg;
    assign report_end  = out_end_reg;

endmodule
`default_nettype wire

// ----- rtl/harf_ctrl.sv -----
// Controller state machine: sequences intervals, quantization and report emission.
`default_nettype none
module harf_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire harf_pkg::harf_sts_t sts,
    output harf_pkg::harf_cmd_t      cmd
);

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b00000000001,
        ST_INT_CHK  = 11'b00000000010,
        ST_Q_MUL1   = 11'b00000000100,
        ST_Q_MUL2   = 11'b00000001000,
        ST_Q_ABS    = 11'b00000010000,
        ST_Q_DIV    = 11'b00000100000,
        ST_Q_PUSH   = 11'b00001000000,
        ST_PUSHED   = 11'b00010000000,
        ST_RPT_RD   = 11'b00100000000,
        ST_RPT_BYTE = 11'b01000000000,
        ST_RPT_WORD = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic chan_reg, chan_next;
    logic ivl_b_reg, ivl_b_next;
    logic flush_reg, flush_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        chan_next  = chan_reg;
        ivl_b_next = ivl_b_reg;
        flush_next = flush_reg;
        cmd        = '0;
        cmd.chan   = chan_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.in_action)
                    begin
                        if (!sts.count_zero)
                        begin
                            flush_next    = 1'b1;
                            cmd.rpt_start = 1'b1;
                            state_next    = ST_RPT_RD;
                        end
                    end
                    else if (sts.have_prev)
                    begin
                        ivl_b_next = 1'b0;
                        state_next = ST_INT_CHK;
                    end
                    else if (sts.in_chunk_end)
                    begin
                        ivl_b_next = 1'b1;
                        state_next = ST_INT_CHK;
                    end
                end
            end
            ST_INT_CHK:
            begin
                if (sts.phase_lt)
                begin
                    chan_next  = 1'b0;
                    state_next = ST_Q_MUL1;
                end
                else
                begin
                    cmd.phase_sub = 1'b1;
                    if (!ivl_b_reg && sts.chunk_end)
                    begin
                        cmd.start_b = 1'b1;
                        ivl_b_next  = 1'b1;
                    end
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_Q_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_Q_MUL2;
            end
            ST_Q_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_Q_ABS;
            end
            ST_Q_ABS:
            begin
                cmd.absq   = 1'b1;
                state_next = ST_Q_DIV;
            end
            ST_Q_DIV:
            begin
                cmd.div_step = 1'b1;
                state_next   = ST_Q_PUSH;
            end
            ST_Q_PUSH:
            begin
                cmd.push = 1'b1;
                if (sts.frame_full_next)
                begin
                    flush_next    = 1'b0;
                    cmd.rpt_start = 1'b1;
                    state_next    = ST_RPT_RD;
                end
                else
                    state_next = ST_PUSHED;
            end
            ST_PUSHED:
            begin
                if (!chan_reg)
                begin
                    chan_next  = 1'b1;
                    state_next = ST_Q_MUL1;
                end
                else
                begin
                    cmd.phase_add = 1'b1;
                    state_next    = ST_INT_CHK;
                end
            end
            ST_RPT_RD:
            begin
                cmd.rpt_rd = 1'b1;
                state_next = ST_RPT_BYTE;
            end
            ST_RPT_BYTE:
            begin
                cmd.rpt_byte = 1'b1;
                state_next   = sts.word_done ? ST_RPT_WORD : ST_RPT_RD;
            end
            ST_RPT_WORD:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (sts.word_end)
                    begin
                        cmd.rpt_finish = 1'b1;
                        state_next     = flush_reg ? ST_IDLE : ST_PUSHED;
                    end
                    else
                        state_next = ST_RPT_RD;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            chan_reg  <= 1'b0;
            ivl_b_reg <= 1'b0;
            flush_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
            ivl_b_reg <= ivl_b_next;
            flush_reg <= flush_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/haptic_audio_report_framer.sv -----
// Top level of the haptic audio report framer: controller plus datapath.
// Input channel (in_valid / in_stall): one request is a stereo frame push
//   (action 0) or a flush of the partial frame (action 1). in_stall is high
//   whenever the block is busy; a request is taken only in the idle state.
// Output channel (out_valid / out_stall): one request is a report word of up
//   to eight bytes, first byte in the low bits; report_end marks the word that
//   holds the last CRC byte. A full report is ceil(REPORT_BYTES/8) words.
// Sequencing: the block takes no new request until a push or flush is done;
//   each output byte goes through the shared quantizer (two multiply
//   stages, a clamp stage, a reciprocal multiply by the fixed scale, the
//   frame memory write). A report is built byte by byte from the frame
//   memory, each byte read and then placed in the word being built; each
//   full word is then loaded into the output register.
// The output word sits in its own register: the next word is built while the
//   receiver stalls, and the block waits only when a second word is ready.
// Reset: configuration returns to 48000 Hz and unity gain; phase, held sample,
//   frame fill, sequence clear; CRC set to all ones. Frame memory is not cleared.
// Configuration writes (cfg_we) take effect at once; write only when idle.
`default_nettype none
module haptic_audio_report_framer #(
    parameter int FRAME_BYTES  = harf_pkg::FRAME_BYTES_DEF,
    parameter int REPORT_BYTES = harf_pkg::REPORT_BYTES_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic                                 cfg_index,
    input  wire logic [harf_pkg::CFG_W-1:0]           cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic                                 action,
    input  wire logic signed [harf_pkg::SAMPLE_W-1:0] left_sample,
    input  wire logic signed [harf_pkg::SAMPLE_W-1:0] right_sample,
    input  wire logic                                 chunk_end,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [harf_pkg::WORD_W-1:0]               report_word,
    output logic [3:0]                                bytes_valid,
    output logic                                      report_end
);

    // command and status between sequencer and datapath
    harf_pkg::harf_cmd_t cmd;
    harf_pkg::harf_sts_t sts;

    harf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    harf_dp #(
        .FRAME_BYTES  (FRAME_BYTES),
        .REPORT_BYTES (REPORT_BYTES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .action       (action),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .chunk_end    (chunk_end),
        .out_stall    (out_stall),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (out_valid),
        .report_word  (report_word),
        .bytes_valid  (bytes_valid),
        .report_end   (report_end)
    );

endmodule
`default_nettype wire

// ----- tb/harf_checker.sv -----
// Report framer checker: snoops both channels and the config port, predicts report words.
`timescale 1ns / 1ps
`default_nettype none
module harf_checker (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic                                 cfg_index,
    input  wire logic [harf_pkg::CFG_W-1:0]           cfg_data,
    input  wire logic                                 in_valid,
    input  wire logic                                 in_stall,
    input  wire logic                                 action,
    input  wire logic signed [harf_pkg::SAMPLE_W-1:0] left_sample,
    input  wire logic signed [harf_pkg::SAMPLE_W-1:0] right_sample,
    input  wire logic                                 chunk_end,
    input  wire logic                                 out_valid,
    input  wire logic                                 out_stall,
    input  wire logic [harf_pkg::WORD_W-1:0]          report_word,
    input  wire logic [3:0]                           bytes_valid,
    input  wire logic                                 report_end,
    output int                                        fail_count,
    output int                                        words_waiting,
    output int                                        requests_seen,
    output int                                        words_seen
);
    import harf_pkg::*;

    localparam logic ACT_FLUSH = 1'b1;
    localparam int   FRAME_N   = FRAME_BYTES_DEF;
    localparam int   REPORT_N  = REPORT_BYTES_DEF;

    typedef struct {
        logic [WORD_W-1:0] data;
        logic [3:0]        nbytes;
        logic              last;
    } report_word_t;

    report_word_t      expected_words[$];
    logic [RATE_W-1:0] rate_hz;
    logic [GAIN_W-1:0] gain;
    int                phase;
    int                held_l;
    int                held_r;
    bit                have_held;
    logic [7:0]        frame_bytes[FRAME_N];
    int                fill;
    logic [3:0]        seq_num;

    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'h0, b};
        for (int k = 0; k < 8; k++)
        begin
            if (r[0])
                r = (r >> 1) ^ 32'hEDB88320;
            else
                r = r >> 1;
        end
        return r;
    endfunction

    // Build the full report from the current frame and queue its words.
    task automatic queue_report();
        logic [7:0]  rep[REPORT_N];
        logic [31:0] crc;
        report_word_t w;
        int          cnt;
        for (int i = 0; i < REPORT_N; i++)
            rep[i] = 8'h00;
        rep[0] = REPORT_ID;
        rep[1] = {seq_num, 4'h0};
        seq_num = seq_num + 4'd1;
        rep[2] = SUB_HEADER;
        rep[3] = 8'(FRAME_N);
        for (int i = 0; i < FRAME_N; i++)
            rep[4 + i] = frame_bytes[i];
        crc = crc_step(32'hFFFFFFFF, CRC_PREFIX);
        for (int i = 0; i < REPORT_N - 4; i++)
            crc = crc_step(crc, rep[i]);
        crc = ~crc;
        for (int i = 0; i < 4; i++)
            rep[REPORT_N - 4 + i] = crc[8*i +: 8];
        for (int off = 0; off < REPORT_N; off += 8)
        begin
            cnt = (REPORT_N - off > 8) ? 8 : REPORT_N - off;
            w.data = '0;
            for (int i = 0; i < cnt; i++)
                w.data[8*i +: 8] = rep[off + i];
            w.nbytes = 4'(cnt);
            w.last = (off + cnt >= REPORT_N);
            expected_words.push_back(w);
        end
    endtask

    task automatic add_byte(input logic [7:0] b);
        frame_bytes[fill] = b;
        fill++;
        if (fill >= FRAME_N)
        begin
            queue_report();
            fill = 0;
        end
    endtask

    // Interpolate, apply gain, clamp, round half away from zero to 8 bits.
    function automatic logic [7:0] scale_sample(input int a, input int b, input int ph);
        longint den;
        longint d2;
        longint num;
        longint q;
        den = longint'(OUTPUT_RATE) * 256;
        d2 = den * 256;
        num = (longint'(a) * (OUTPUT_RATE - ph) + longint'(b) * ph) * longint'(gain);
        if (num > 32767 * den)
            num = 32767 * den;
        if (num < -32768 * den)
            num = -32768 * den;
        if (num >= 0)
            q = (num + d2 / 2) / d2;
        else
            q = -((-num + d2 / 2) / d2);
        if (q > 127)
            q = 127;
        if (q < -128)
            q = -128;
        return q[7:0];
    endfunction

    task automatic walk_interval(input int al, input int ar, input int bl, input int br,
                                 input int stride);
        while (phase < OUTPUT_RATE)
        begin
            add_byte(scale_sample(al, bl, phase));
            add_byte(scale_sample(ar, br, phase));
            phase += stride;
        end
        phase -= OUTPUT_RATE;
    endtask

    task automatic predict_request();
        int stride;
        if (action == ACT_FLUSH)
        begin
            if (fill != 0)
            begin
                for (int i = fill; i < FRAME_N; i++)
                    frame_bytes[i] = 8'h00;
                queue_report();
                fill = 0;
            end
        end
        else
        begin
            stride = (rate_hz < OUTPUT_RATE) ? OUTPUT_RATE : int'(rate_hz);
            if (have_held)
                walk_interval(held_l, held_r, left_sample, right_sample, stride);
            held_l = left_sample;
            held_r = right_sample;
            have_held = 1;
            if (chunk_end)
            begin
                walk_interval(left_sample, right_sample, left_sample, right_sample, stride);
                have_held = 0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        report_word_t exp_w;
        if (!rst_n)
        begin
            expected_words.delete();
            rate_hz = RATE_RESET;
            gain = GAIN_RESET;
            phase = 0;
            held_l = 0;
            held_r = 0;
            have_held = 0;
            fill = 0;
            seq_num = 4'h0;
            fail_count = 0;
            requests_seen = 0;
            words_seen = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_IDX_RATE)
                    rate_hz = cfg_data[RATE_W-1:0];
                else
                    gain = cfg_data[GAIN_W-1:0];
            end
            if (out_valid && !out_stall)
            begin
                words_seen++;
                if (expected_words.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("ERROR: unexpected word %h nbytes %0d end %b",
                                 report_word, bytes_valid, report_end);
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    if (report_word !== exp_w.data || bytes_valid !== exp_w.nbytes
                        || report_end !== exp_w.last)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("ERROR: word %0d exp %h/%0d/%b got %h/%0d/%b",
                                     words_seen, exp_w.data, exp_w.nbytes, exp_w.last,
                                     report_word, bytes_valid, report_end);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                requests_seen++;
                predict_request();
            end
        end
        words_waiting = expected_words.size();
    end
endmodule
`default_nettype wire

// ----- tb/tb_haptic_audio_report_framer.sv -----
// Testbench top for the haptic audio report framer: stimulus, idling and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_haptic_audio_report_framer;
    import harf_pkg::*;

    localparam logic ACT_PUSH  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;
    localparam int   DRAIN_CYCLES = 6000;   // longest push plus a whole report, with margin
    localparam int   STALL_LIMIT  = 20000;  // cycles with no request moving on either side

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic                       cfg_index;
    logic [CFG_W-1:0]           cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    logic                       action;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       chunk_end;
    logic                       out_valid;
    logic                       out_stall;
    logic [WORD_W-1:0]          report_word;
    logic [3:0]                 bytes_valid;
    logic                       report_end;

    int  fail_count;
    int  words_waiting;
    int  requests_seen;
    int  words_seen;
    bit  sender_quiet;      // no gaps from the sender while set
    bit  hold_off_req;      // ask the receiver for one long hold-off
    int  idle_cycles;

    haptic_audio_report_framer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .left_sample (left_sample),
        .right_sample(right_sample),
        .chunk_end   (chunk_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .report_word (report_word),
        .bytes_valid (bytes_valid),
        .report_end  (report_end)
    );

    harf_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .chunk_end    (chunk_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .report_word  (report_word),
        .bytes_valid  (bytes_valid),
        .report_end   (report_end),
        .fail_count   (fail_count),
        .words_waiting(words_waiting),
        .requests_seen(requests_seen),
        .words_seen   (words_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver: random stalls, a clean stretch early on, and one long
    // hold-off on request so the block backs up into its input.
    initial
    begin
        int cyc;
        cyc = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (900) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (cyc > 3000 && cyc < 9000)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < 22);
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("ERROR: timeout, no request moved for %0d cycles", STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Offer one request and hold it until taken; then maybe drop valid for a gap.
    task automatic send_request(input logic act, input logic [15:0] l, input logic [15:0] r,
                                input logic ce);
        in_valid     <= 1'b1;
        action       <= act;
        left_sample  <= l;
        right_sample <= r;
        chunk_end    <= ce;
        do
            @(posedge clk);
        while (in_stall);
        if (!sender_quiet && $urandom_range(0, 99) < 22)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Let the block settle, then load both registers.
    task automatic load_config(input logic [RATE_W-1:0] rate, input logic [GAIN_W-1:0] g);
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_waiting != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_RATE;
        cfg_data  <= CFG_W'(rate);
        @(posedge clk);
        cfg_index <= CFG_IDX_GAIN;
        cfg_data  <= CFG_W'(g);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'(int'($urandom_range(0, 600)) - 300);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        int rates[8] = '{0, 192000, 262143, 44100, 3000, 8000, 48000, 1000};
        int gains[8] = '{65535, 0, 256, 300, 128, 512, 256, 1};
        cfg_we = 1'b0;
        cfg_index = CFG_IDX_RATE;
        cfg_data = '0;
        in_valid = 1'b0;
        action = ACT_PUSH;
        left_sample = '0;
        right_sample = '0;
        chunk_end = 1'b0;
        sender_quiet = 1'b0;
        hold_off_req = 1'b0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: one output position per interval at 3000 Hz, unity gain.
        load_config(18'd3000, 16'd256);
        send_request(ACT_FLUSH, 16'h0000, 16'h0000, 1'b0);   // flush with empty frame
        send_request(ACT_PUSH, 16'h7FFF, 16'h8000, 1'b0);    // first of chunk: stored only
        send_request(ACT_PUSH, 16'h8000, 16'h7FFF, 1'b0);
        send_request(ACT_PUSH, 16'h0000, 16'hFFFF, 1'b0);
        send_request(ACT_PUSH, 16'h0080, 16'hFF80, 1'b1);    // chunk end, hold last sample
        send_request(ACT_PUSH, 16'h1234, 16'hEDCC, 1'b1);    // single-sample chunk
        send_request(ACT_PUSH, 16'h00C0, 16'hFF40, 1'b0);    // half-step rounding values
        send_request(ACT_PUSH, 16'h0180, 16'hFE80, 1'b1);
        send_request(ACT_FLUSH, 16'hFFFF, 16'hFFFF, 1'b1);   // flush partial frame
        send_request(ACT_FLUSH, 16'h0000, 16'h0000, 1'b0);   // frame now empty again
        for (int i = 0; i < 40; i++)                          // fill one whole frame
            send_request(ACT_PUSH, 16'(i * 1637), 16'(-i * 811), (i % 13) == 12);
        load_config(18'd0, 16'hFFFF);                        // slow rate, full gain
        send_request(ACT_PUSH, 16'h7FFF, 16'h8000, 1'b0);
        send_request(ACT_PUSH, 16'h0101, 16'hFEFF, 1'b1);
        send_request(ACT_FLUSH, 16'h0000, 16'h0000, 1'b0);

        // Random phases across the register settings.
        for (int p = 0; p < 8; p++)
        begin
            load_config(RATE_W'(rates[p]), GAIN_W'(gains[p]));
            sender_quiet = (p == 4);
            if (p == 3)
                hold_off_req = 1'b1;
            for (int i = 0; i < 15; i++)
            begin
                if ($urandom_range(0, 99) < 9)
                    send_request(ACT_FLUSH, 16'($urandom), 16'($urandom), 1'($urandom));
                else
                    send_request(ACT_PUSH, pick_sample(), pick_sample(),
                                 $urandom_range(0, 99) < 15);
            end
            send_request(ACT_FLUSH, 16'h0000, 16'h0000, 1'b0);
        end
        in_valid <= 1'b0;

        // Drain: wait for every expected word, then for the block to go quiet.
        @(posedge clk);
        while (words_waiting != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests and %0d report words over 10 register settings,",
                 requests_seen, words_seen);
        $display("with random sender gaps, receiver stalls and one long output hold-off.");
        if (fail_count == 0 && words_waiting == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire

// ----- haptic_audio_report_framer.f -----
rtl/harf_pkg.sv
rtl/harf_dp.sv
rtl/harf_ctrl.sv
rtl/haptic_audio_report_framer.sv
tb/harf_checker.sv
tb/tb_haptic_audio_report_framer.sv
